// File: src/i2p_pkg.sv
package i2p_pkg;

  // Characters with a special role in the conversion.
  localparam logic [7:0] CH_POW   = 8'h5E;  // '^'
  localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UC_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_DIG_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_DIG_9 = 8'h39;  // '9'

  // Precedence levels.
  localparam logic [2:0] PREC_POW  = 3'd5;
  localparam logic [2:0] PREC_MUL  = 3'd4;
  localparam logic [2:0] PREC_ADD  = 3'd3;
  localparam logic [2:0] PREC_OPEN = 3'd2;
  localparam logic [2:0] PREC_NONE = 3'd0;

  typedef struct packed {
    logic [7:0] symbol_in;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol_out;
    logic       symbol_valid;
    logic       last_in_run;
    logic       expr_done;
    logic       overflow_seen;
    logic       unmatched_seen;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_CLOSE,
    S_FLUSH
  } state_t;

  function automatic logic [2:0] prec_of(input logic [7:0] c);
    logic [2:0] p;
    case (c)
      CH_POW:         p = PREC_POW;
      CH_MUL, CH_DIV: p = PREC_MUL;
      CH_ADD, CH_SUB: p = PREC_ADD;
      CH_OPEN:        p = PREC_OPEN;
      default:        p = PREC_NONE;
    endcase
    return p;
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_ADD) || (c == CH_SUB) || (c == CH_MUL) || (c == CH_DIV) ||
           (c == CH_POW);
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_DIG_0) && (c <= CH_DIG_9));
  endfunction

endpackage

// File: src/i2p_ram.sv
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port, registered read port (old data on a same-address write).
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/infix_to_postfix_converter_top.sv
// Shunting-yard infix to postfix converter. One ASCII character enters per input
// item and the postfix characters leave as result items, each result carrying the
// last-in-run mark, the end-of-expression mark and the two sticky error flags.
// The operator stack lives in a RAM with a registered read; the top entry is
// always prefetched, so each step can pop one entry. An operand, '(' or an
// ignored character is handled as it is taken. An operator pops the entries
// above it of equal or higher precedence and is then pushed, a ')' pops the
// operators above its '(' (the '(' itself leaves with the closing result), and
// an end item pops every stacked entry. A result waits in the output register
// while the next item is taken; a stalled output stops the converter once it has a result to give.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2p_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output i2p_pkg::out_item_t  out_item
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  i2p_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      open_r, open_nxt;
  logic               ovf_r, ovf_nxt;
  logic               unm_r, unm_nxt;
  logic [7:0]         cur_r, cur_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic               have_pend_r, have_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  i2p_pkg::out_item_t out_r, out_nxt;
  logic               fwd_r;
  logic [7:0]         fwd_data_r;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_data;
  logic [CW-1:0]      cnt_m1;
  logic [7:0]         top_sym;
  logic               slot_free;
  logic               pop_ok;
  logic               pop_op;
  logic               pop_open;
  logic               finish;
  logic               emit;
  i2p_pkg::out_item_t emit_item;

  // Operator stack storage.
  i2p_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Prefetch the entry that will be on top next cycle.
  assign cnt_m1  = count_nxt - ONE;
  assign rd_addr = (count_nxt == '0) ? '0 : cnt_m1[AW-1:0];

  // A push to the address being read returns stale data; forward the new value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
    fwd_data_r <= wr_data;
  end

  assign top_sym   = fwd_r ? fwd_data_r : rd_data;
  assign slot_free = !out_valid_r || out_ready;
  assign pop_ok    = (count_r != '0);

  // State register and stack bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2p_pkg::S_IDLE;
      count_r     <= '0;
      open_r      <= '0;
      ovf_r       <= 1'b0;
      unm_r       <= 1'b0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      open_r      <= open_nxt;
      ovf_r       <= ovf_nxt;
      unm_r       <= unm_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // Next state, stack updates and result generation.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    open_nxt      = open_r;
    ovf_nxt       = ovf_r;
    unm_nxt       = unm_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = cur_r;
    in_ready      = 1'b0;
    pop_op        = 1'b0;
    pop_open      = 1'b0;
    finish        = 1'b0;
    emit          = 1'b0;
    emit_item     = '0;

    unique case (state_r)
      i2p_pkg::S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (in_item.end_of_expr) begin
            have_pend_nxt = 1'b0;
            state_nxt     = i2p_pkg::S_FLUSH;
          end else if (in_item.symbol_in == i2p_pkg::CH_OPEN) begin
            // Push '(' right away and report status.
            if (count_r < FULL) begin
              wr_en     = 1'b1;
              wr_data   = in_item.symbol_in;
              count_nxt = count_r + ONE;
              open_nxt  = open_r + ONE;
            end else begin
              ovf_nxt = 1'b1;
            end
            emit                  = 1'b1;
            emit_item.last_in_run = 1'b1;
          end else if (i2p_pkg::is_operand(in_item.symbol_in)) begin
            emit                   = 1'b1;
            emit_item.symbol_out   = in_item.symbol_in;
            emit_item.symbol_valid = 1'b1;
            emit_item.last_in_run  = 1'b1;
          end else if (i2p_pkg::is_operator(in_item.symbol_in)) begin
            cur_nxt       = in_item.symbol_in;
            have_pend_nxt = 1'b0;
            state_nxt     = i2p_pkg::S_OPER;
          end else if (in_item.symbol_in == i2p_pkg::CH_CLOSE) begin
            // With no '(' stacked the close is unmatched from the start.
            if (open_r == '0) begin
              unm_nxt = 1'b1;
            end
            have_pend_nxt = 1'b0;
            state_nxt     = i2p_pkg::S_CLOSE;
          end else begin
            emit                  = 1'b1;
            emit_item.last_in_run = 1'b1;
          end
        end
      end
      i2p_pkg::S_OPER: begin
        if (pop_ok && (i2p_pkg::prec_of(top_sym) >= i2p_pkg::prec_of(cur_r))) begin
          pop_op = 1'b1;
        end else if (slot_free) begin
          finish = 1'b1;
          if (count_r < FULL) begin
            wr_en     = 1'b1;
            count_nxt = count_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      i2p_pkg::S_CLOSE: begin
        if (pop_ok && (top_sym != i2p_pkg::CH_OPEN)) begin
          pop_op = 1'b1;
        end else if (slot_free) begin
          finish   = 1'b1;
          pop_open = pop_ok;
        end
      end
      i2p_pkg::S_FLUSH: begin
        if (pop_ok && (top_sym == i2p_pkg::CH_OPEN)) begin
          pop_open = 1'b1;
        end else if (pop_ok) begin
          pop_op = 1'b1;
        end else if (slot_free) begin
          finish  = 1'b1;
          ovf_nxt = 1'b0;
          unm_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = i2p_pkg::S_IDLE;
      end
    endcase

    // An operator pop is held back in the pending register so that the last one can be marked.
    if (pop_op) begin
      if (!have_pend_r) begin
        pend_nxt      = top_sym;
        have_pend_nxt = 1'b1;
        count_nxt     = count_r - ONE;
      end else if (slot_free) begin
        emit                   = 1'b1;
        emit_item.symbol_out   = pend_r;
        emit_item.symbol_valid = 1'b1;
        pend_nxt               = top_sym;
        count_nxt              = count_r - ONE;
      end
    end

    // A '(' leaves the stack without producing output.
    if (pop_open) begin
      count_nxt = count_r - ONE;
      open_nxt  = open_r - ONE;
    end

    // The closing result of a multi-cycle item.
    if (finish) begin
      emit                   = 1'b1;
      emit_item.symbol_out   = have_pend_r ? pend_r : 8'h00;
      emit_item.symbol_valid = have_pend_r;
      emit_item.last_in_run  = 1'b1;
      emit_item.expr_done    = (state_r == i2p_pkg::S_FLUSH);
      have_pend_nxt          = 1'b0;
      state_nxt              = i2p_pkg::S_IDLE;
    end

    // Flags report their value after the item; an end item reports before clearing.
    emit_item.overflow_seen  = (state_r == i2p_pkg::S_FLUSH) ? ovf_r : ovf_nxt;
    emit_item.unmatched_seen = (state_r == i2p_pkg::S_FLUSH) ? unm_r : unm_nxt;

    // Output register.
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = emit_item;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_nxt       = out_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  // The stack never holds more than its depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= FULL)
    else $error("stack count beyond depth");

  // Stacked '(' entries are a subset of all stacked entries.
  assert property (@(posedge clk) disable iff (!rst_n) open_r <= count_r)
    else $error("open parenthesis count exceeds stack count");

  // An end-of-expression result always closes its run.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r && out_r.expr_done |-> out_r.last_in_run)
    else $error("expression done without last in run");

  // An accepted item either produces a result at once or starts a pop sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
                   in_valid && in_ready |=> out_valid_r || (state_r != i2p_pkg::S_IDLE))
    else $error("accepted item left no trace");
`endif

endmodule
